@@ rtl/bounded_deque_defines.svh @@
// ---------------------------------------------------------------------------
// bounded_deque_defines.svh
// Assertion macros shared by the deque RTL. Each expects clk_i, and BD_ASSERT
// also rst_ni, in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_DEFINES_SVH
`define BOUNDED_DEQUE_DEFINES_SVH

// Checked on every rising edge outside reset
`define BD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bounded_deque assertion failed");

// Checked on every rising edge, reset included
`define BD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("bounded_deque assertion failed");

`endif

@@ rtl/bd_pkg.sv @@
// ---------------------------------------------------------------------------
// bd_pkg
// Request codes, status codes and the memory control group of the deque.
// ---------------------------------------------------------------------------
package bd_pkg;

  // Request codes carried on req_type
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DUMP       = 3'd4
  } req_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Strobes from the controller to the slot memory
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

@@ rtl/bd_ram.sv @@
// ---------------------------------------------------------------------------
// bd_ram
// Slot memory of the deque: one write port, one read port, registered
// read data. Read data holds until the next read.
// ---------------------------------------------------------------------------
module bd_ram #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic                clk_i,
  input  bd_pkg::mem_ctl_t    ctl_i,
  input  logic [IW-1:0]       wr_addr_i,
  input  logic signed [31:0]  wr_data_i,
  input  logic [IW-1:0]       rd_addr_i,
  output logic signed [31:0]  rd_data_o
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/bounded_deque.sv @@
// ---------------------------------------------------------------------------
// bounded_deque
// Bounded double-ended queue of 32-bit signed values in a ring of DEPTH
// slots, tracked by a front index and an entry count.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  req_type_i, item_value_i
//   out      output     out_valid_o/out_ready_i status_o, out_value_o, last_o
//
// A push, or a pop or dump on an empty store, sets the output register
// directly; an unused code gives no result. A returned pop value passes
// the registered memory read. A dump reads memory once per stored value.
// Reset clears front index and count; slot contents are never cleared.
// A stalled output holds the controller; a request is taken only when the
// output register is free or being drained in the same cycle.
// ---------------------------------------------------------------------------
`include "bounded_deque_defines.svh"

module bounded_deque #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         req_type_i,
  input  logic signed [31:0] item_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] out_value_o,
  output logic               last_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [IW-1:0] IdxMax = IW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_e;

  state_e             state_q;
  logic [IW-1:0]      front_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      idx_q;
  logic               out_valid_q;
  bd_pkg::status_e    status_q;
  logic signed [31:0] out_value_q;
  logic               last_q;

  bd_pkg::req_e       req;
  bd_pkg::mem_ctl_t   mem_ctl;
  logic [IW-1:0]      wr_addr;
  logic [IW-1:0]      rd_addr;
  logic signed [31:0] rd_data;
  logic               accept;
  logic               out_free;
  logic               full;
  logic               empty;
  logic               push_ok;
  logic [IW-1:0]      front_dec;
  logic [IW-1:0]      front_inc;
  logic [CW-1:0]      dump_nxt;
  logic               dump_last;

  // Ring slot of base + off; base stays below DEPTH and off is at most DEPTH
  function automatic logic [IW-1:0] ring_add(logic [IW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  // Handshake and occupancy
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign req        = bd_pkg::req_e'(req_type_i);
  assign full       = (count_q == DepthC);
  assign empty      = (count_q == '0);
  assign push_ok    = accept && !full &&
                      (req == bd_pkg::REQ_PUSH_FRONT || req == bd_pkg::REQ_PUSH_BACK);
  assign front_dec  = (front_q == '0) ? IdxMax : front_q - IW'(1);
  assign front_inc  = (front_q == IdxMax) ? '0 : front_q + IW'(1);
  assign dump_nxt   = idx_q + CW'(1);
  assign dump_last  = (dump_nxt == count_q);

  // Memory addresses and strobes
  always_comb begin
    wr_addr       = (req == bd_pkg::REQ_PUSH_FRONT) ? front_dec : ring_add(front_q, count_q);
    rd_addr       = front_q;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    if (state_q == S_IDLE) begin
      if (req == bd_pkg::REQ_POP_BACK) begin
        rd_addr = ring_add(front_q, count_q - CW'(1));
      end
      if (accept) begin
        mem_ctl.wr_en = !full &&
                        (req == bd_pkg::REQ_PUSH_FRONT || req == bd_pkg::REQ_PUSH_BACK);
        mem_ctl.rd_en = !empty && (req == bd_pkg::REQ_POP_FRONT ||
                        req == bd_pkg::REQ_POP_BACK || req == bd_pkg::REQ_DUMP);
      end
    end else if (state_q == S_DUMP) begin
      rd_addr       = ring_add(front_q, dump_nxt);
      mem_ctl.rd_en = out_free && !dump_last;
    end
  end

  bd_ram #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_ram (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i (item_value_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Controller: state, ring pointers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= bd_pkg::STAT_OK;
      out_value_q <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (req)
              bd_pkg::REQ_PUSH_FRONT, bd_pkg::REQ_PUSH_BACK: begin
                out_valid_q <= 1'b1;
                out_value_q <= '0;
                last_q      <= 1'b1;
                if (full) begin
                  status_q <= bd_pkg::STAT_FULL;
                end else begin
                  status_q <= bd_pkg::STAT_OK;
                  count_q  <= count_q + CW'(1);
                  if (req == bd_pkg::REQ_PUSH_FRONT) begin
                    front_q <= front_dec;
                  end
                end
              end
              bd_pkg::REQ_POP_FRONT, bd_pkg::REQ_POP_BACK: begin
                if (empty) begin
                  out_valid_q <= 1'b1;
                  status_q    <= bd_pkg::STAT_EMPTY;
                  out_value_q <= '0;
                  last_q      <= 1'b1;
                end else begin
                  count_q <= count_q - CW'(1);
                  if (req == bd_pkg::REQ_POP_FRONT) begin
                    front_q <= front_inc;
                  end
                  state_q <= S_POP;
                end
              end
              bd_pkg::REQ_DUMP: begin
                if (empty) begin
                  out_valid_q <= 1'b1;
                  status_q    <= bd_pkg::STAT_EMPTY;
                  out_value_q <= '0;
                  last_q      <= 1'b1;
                end else begin
                  idx_q   <= '0;
                  state_q <= S_DUMP;
                end
              end
              default: ;  // unused codes give no result
            endcase
          end
        end
        S_POP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= bd_pkg::STAT_OK;
            out_value_q <= rd_data;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= bd_pkg::STAT_OK;
            out_value_q <= rd_data;
            last_q      <= dump_last;
            if (dump_last) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= dump_nxt;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;

  // Checks
  `BD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_q)
  `BD_ASSERT(a_count_bound, count_q <= DepthC)
  `BD_ASSERT(a_front_bound, front_q <= IdxMax)
  `BD_ASSERT(a_dump_idx, state_q == S_DUMP |-> idx_q < count_q && count_q != '0)
  `BD_ASSERT(a_push_count, push_ok |=> count_q == $past(count_q) + CW'(1))
  `BD_ASSERT(a_pop_result, state_q == S_POP && out_free |=> out_valid_q && last_q && status_q == bd_pkg::STAT_OK)

endmodule

@@ sim/bounded_deque_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bounded_deque_tb
// Self-checking bench for the bounded deque. A directed table covers empty
// and full stores, the value extremes, every request code and two of the
// reserved codes. Shaped random traffic follows under four idling phases, with one
// long output hold-off. Every result transaction is checked field by field
// against an in-bench model of the ring store.
// ---------------------------------------------------------------------------
module bounded_deque_tb;

  localparam int DEPTH       = 16;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 80;

  // Request codes the block ignores
  localparam logic [2:0] REQ_RSVD5 = 3'd5;
  localparam logic [2:0] REQ_RSVD6 = 3'd6;
  localparam logic [2:0] REQ_RSVD7 = 3'd7;

  // Traffic shapes for the random part
  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mode_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [2:0]  code;
    logic [31:0] value;
    logic        typed;
    logic [1:0]  exp_status;
    logic [31:0] exp_value;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         req_type_i = bd_pkg::REQ_PUSH_FRONT;
  logic signed [31:0] item_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] out_value_o;
  logic               last_o;

  // Ring store mirror
  logic [31:0] ring_slots [DEPTH];
  int          ring_head;
  int          ring_count;
  result_t     results_due [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  // Long output hold-off, requested by toggling
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  // Directed stimulus; typed rows carry their result inline
  stim_row_t directed_rows [28] = '{
    '{bd_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b1, bd_pkg::STAT_EMPTY, 32'h0000_0000},
    '{bd_pkg::REQ_POP_BACK,   32'h0000_0000, 1'b1, bd_pkg::STAT_EMPTY, 32'h0000_0000},
    '{bd_pkg::REQ_DUMP,       32'h0000_0000, 1'b1, bd_pkg::STAT_EMPTY, 32'h0000_0000},
    '{REQ_RSVD5,              32'h1234_5678, 1'b0, bd_pkg::STAT_OK,    32'h0000_0000},
    '{REQ_RSVD7,              32'hFFFF_FFFF, 1'b0, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_POP_BACK,   32'h0000_0000, 1'b1, bd_pkg::STAT_OK,    32'h7FFF_FFFF},
    '{bd_pkg::REQ_POP_FRONT,  32'h0000_0000, 1'b1, bd_pkg::STAT_OK,    32'h8000_0000},
    '{bd_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_BACK,  32'h0000_0000, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_FRONT, 32'h0000_0001, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_FRONT, 32'h8000_0000, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_BACK,  32'h5555_5555, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_BACK,  32'h0000_FFFF, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_FRONT, 32'hFFFF_0000, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_BACK,  32'h1234_5678, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_FRONT, 32'h8765_4321, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_BACK,  32'h0F0F_0F0F, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_FRONT, 32'hF0F0_F0F0, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_BACK,  32'h0000_0002, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFE, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_BACK,  32'h3C3C_3C3C, 1'b1, bd_pkg::STAT_OK,    32'h0000_0000},
    '{bd_pkg::REQ_PUSH_BACK,  32'h0000_0011, 1'b1, bd_pkg::STAT_FULL,  32'h0000_0000},
    '{bd_pkg::REQ_PUSH_FRONT, 32'h0000_0022, 1'b1, bd_pkg::STAT_FULL,  32'h0000_0000},
    '{bd_pkg::REQ_DUMP,       32'h0000_0000, 1'b0, bd_pkg::STAT_OK,    32'h0000_0000}
  };

  bounded_deque #(.DEPTH(DEPTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .out_value_o  (out_value_o),
    .last_o       (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Queue one expected result transaction
  function automatic void owe_result(logic [1:0] st, logic [31:0] val, logic lst);
    result_t r;
    r.status = st;
    r.value  = val;
    r.last   = lst;
    results_due.push_back(r);
  endfunction

  // Advance the mirror by one accepted request and queue what it produces
  function automatic void apply_request(logic [2:0] code, logic [31:0] val);
    int i;
    case (code)
      bd_pkg::REQ_PUSH_FRONT, bd_pkg::REQ_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          owe_result(bd_pkg::STAT_FULL, '0, 1'b1);
        end else begin
          if (code == bd_pkg::REQ_PUSH_FRONT) begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring_slots[ring_head] = val;
          end else begin
            ring_slots[(ring_head + ring_count) % DEPTH] = val;
          end
          ring_count++;
          owe_result(bd_pkg::STAT_OK, '0, 1'b1);
        end
      end
      bd_pkg::REQ_POP_FRONT: begin
        if (ring_count == 0) begin
          owe_result(bd_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          owe_result(bd_pkg::STAT_OK, ring_slots[ring_head], 1'b1);
          ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
        end
      end
      bd_pkg::REQ_POP_BACK: begin
        if (ring_count == 0) begin
          owe_result(bd_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          owe_result(bd_pkg::STAT_OK, ring_slots[(ring_head + ring_count - 1) % DEPTH],
                     1'b1);
          ring_count--;
        end
      end
      bd_pkg::REQ_DUMP: begin
        if (ring_count == 0) begin
          owe_result(bd_pkg::STAT_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < ring_count; i++) begin
            owe_result(bd_pkg::STAT_OK, ring_slots[(ring_head + i) % DEPTH],
                       (i + 1 == ring_count));
          end
        end
      end
      default: ; // reserved codes: no transaction out
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    if (mismatch_count < 40) begin
      $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
    end
    mismatch_count++;
  endtask

  // Offer one request from the falling edge and hold it until taken
  task automatic send_req(logic [2:0] code, logic [31:0] val);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= code;
    item_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Mostly random values, sometimes an extreme
  function automatic logic [31:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls plus a long hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen   <= hold_toggle;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with none pending", '0, out_value_o);
      end else begin
        want = results_due.pop_front();
        if (status_o !== want.status) begin
          report_mismatch("status", 32'(want.status), 32'(status_o));
        end
        if (out_value_o !== want.value) report_mismatch("out_value", want.value, out_value_o);
        if (last_o !== want.last) report_mismatch("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d results pending", results_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Stimulus
  initial begin
    int idle_tbl [4];
    int stall_tbl [4];
    int ph;
    int row;
    int sent;
    int r;
    int push_thr;
    logic [2:0] code;
    mode_e mode;

    idle_tbl  = '{0, 49, 0, 26};
    stall_tbl = '{0, 0, 49, 26};
    ring_head  = 0;
    ring_count = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    for (row = 0; row < $size(directed_rows); row++) begin
      send_req(directed_rows[row].code, directed_rows[row].value);
      apply_request(directed_rows[row].code, directed_rows[row].value);
      if (directed_rows[row].typed) begin
        void'(results_due.pop_back());
        owe_result(directed_rows[row].exp_status, directed_rows[row].exp_value, 1'b1);
      end
    end

    // Random traffic, one idling setting per phase
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tbl[ph];
      recv_stall_pct = stall_tbl[ph];
      if (ph == 0) hold_toggle = ~hold_toggle;
      sent = 0;
      mode = MODE_FILL;
      while (sent < PHASE_ITEMS) begin
        // Pick at random between filling, draining and balanced traffic
        if (sent % 24 == 0) begin
          case ($urandom_range(2))
            0:       mode = MODE_FILL;
            1:       mode = MODE_DRAIN;
            default: mode = MODE_MIXED;
          endcase
        end
        push_thr = (mode == MODE_FILL) ? 73 : (mode == MODE_DRAIN) ? 33 : 55;
        r = $urandom_range(99);
        if (r < 3) begin
          case ($urandom_range(2))
            0:       code = REQ_RSVD5;
            1:       code = REQ_RSVD6;
            default: code = REQ_RSVD7;
          endcase
        end else if (r < 11) begin
          code = bd_pkg::REQ_DUMP;
        end else if (r < push_thr) begin
          code = $urandom_range(1) ? bd_pkg::REQ_PUSH_BACK : bd_pkg::REQ_PUSH_FRONT;
        end else begin
          code = $urandom_range(1) ? bd_pkg::REQ_POP_BACK : bd_pkg::REQ_POP_FRONT;
        end
        send_req(code, pick_value());
        apply_request(code, item_value_i);
        if (code <= bd_pkg::REQ_DUMP) sent++;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then give stray results a chance to show up
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
